// ===== sv/gcdist_pkg.sv =====
package gcdist_pkg;

	// Input angle format: degrees with this many fractional bits
	localparam int ANGLE_FRAC_BITS = 16;

	localparam int LAT_W = 24;
	localparam int LON_W = 25;
	localparam int DIST_W = 25;

	// Lanes: first latitude, second latitude, longitude difference
	localparam int LANES = 3;
	localparam int LANE_LAT1 = 0;
	localparam int LANE_LAT2 = 1;
	localparam int LANE_DLON = 2;

	// Angle reduction
	localparam int ANG_IN_W = LON_W + 1;
	localparam longint FULL_TURN = longint'(360) << ANGLE_FRAC_BITS;
	localparam longint HALF_TURN = longint'(180) << ANGLE_FRAC_BITS;
	localparam longint QUARTER_TURN = longint'(90) << ANGLE_FRAC_BITS;
	localparam longint FULL_RECIP = (longint'(1) << ANG_IN_W) / FULL_TURN;
	localparam int RED_W = ((ANG_IN_W > ANGLE_FRAC_BITS + 9) ?
		ANG_IN_W : ANGLE_FRAC_BITS + 9) + 1;
	localparam int MAG_W = ANGLE_FRAC_BITS + 7;

	// Degrees to Q30 radians: pi split as 45 * PI_HI + PI_LO
	localparam longint PI_Q30 = 64'd3373259426;
	localparam longint PI_HI = PI_Q30 / 45;
	localparam longint PI_LO = PI_Q30 % 45;
	localparam int PI_HI_W = 27;
	localparam int T_W = MAG_W + PI_HI_W;
	localparam int U_W = ANGLE_FRAC_BITS + 12;
	localparam longint RECIP45 = (longint'(1) << U_W) / 45;

	// CORDIC
	localparam int CW = 34;
	localparam int CORDIC_STEPS = 30;
	localparam longint GAIN_INV = 652032874;
	localparam longint HALF_PI_Q30 = 1686629713;
	localparam logic [31:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
		32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
		32'd32, 32'd16, 32'd8, 32'd4, 32'd2
	};

	// Square root: one result bit per stage
	localparam int SQRT_STEPS = 31;

	localparam longint EARTH_RADIUS_M = 6371000;
	localparam longint MAX_DISTANCE = 20015087;

	// Pipeline depth: reduction and scaling 6, rotation 30, products 3,
	// square 2, root 31, swap 1, vectoring 30, distance 2
	localparam int DEPTH = 6 + CORDIC_STEPS + 3 + 2 + SQRT_STEPS + 1 + CORDIC_STEPS + 2;

endpackage

// ===== sv/gcdist_in_if.sv =====
interface gcdist_in_if import gcdist_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [LAT_W-1:0] first_latitude;
	logic signed [LON_W-1:0] first_longitude;
	logic signed [LAT_W-1:0] second_latitude;
	logic signed [LON_W-1:0] second_longitude;

	modport source(
		output valid, first_latitude, first_longitude, second_latitude, second_longitude,
		input ready
	);
	modport sink(
		input valid, first_latitude, first_longitude, second_latitude, second_longitude,
		output ready
	);
endinterface

// ===== sv/gcdist_out_if.sv =====
interface gcdist_out_if import gcdist_pkg::*; ();
	logic valid;
	logic ready;
	logic [DIST_W-1:0] distance_m;
	logic missing_coordinate;

	modport source(output valid, distance_m, missing_coordinate, input ready);
	modport sink(input valid, distance_m, missing_coordinate, output ready);
endinterface

// ===== sv/great_circle_distance.sv =====
// Great-circle distance, spherical law of cosines, fully pipelined.
// Throughput: one item per cycle; a result held at the output freezes every stage,
// so the next item is taken as soon as the output register is free or drained.
// Reset (arst_n low) clears the stage valid bits and missing flags only; the
// datapath registers are not reset and carry no meaning until refilled.
module great_circle_distance import gcdist_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gcdist_in_if.sink points,
	gcdist_out_if.source result
);

	// Constants sized for the datapath
	localparam logic [ANG_IN_W-1:0] FULL_RECIP_V = ANG_IN_W'(FULL_RECIP);
	localparam logic [RED_W-1:0] FULL_V = RED_W'(FULL_TURN);
	localparam logic [RED_W-1:0] HALF_V = RED_W'(HALF_TURN);
	localparam logic signed [RED_W-1:0] HALF_S = RED_W'(HALF_TURN);
	localparam logic signed [RED_W-1:0] NEG_HALF_S = RED_W'(-HALF_TURN);
	localparam logic signed [RED_W-1:0] QUARTER_S = RED_W'(QUARTER_TURN);
	localparam logic signed [RED_W-1:0] NEG_QUARTER_S = RED_W'(-QUARTER_TURN);
	localparam logic [T_W-1:0] PI_HI_V = T_W'(PI_HI);
	localparam logic [U_W-1:0] PI_LO_V = U_W'(PI_LO);
	localparam logic [U_W-1:0] U_OFFSET = U_W'(longint'(45) << (ANGLE_FRAC_BITS + 1));
	localparam logic [U_W-1:0] RECIP45_V = U_W'(RECIP45);
	localparam logic [U_W-1:0] DIV45_V = U_W'(45);
	localparam logic signed [CW-1:0] GAIN_INV_V = CW'(GAIN_INV);
	localparam logic signed [CW-1:0] HALF_PI_V = CW'(HALF_PI_Q30);
	localparam logic signed [63:0] ROUND_Q30 = 64'sd536870912;
	localparam logic signed [63:0] ONE_Q60 = 64'sd1152921504606846976;
	localparam logic signed [63:0] V_MAX = 64'sd1073741824;
	localparam logic signed [63:0] V_MIN = -64'sd1073741824;
	localparam logic [54:0] RADIUS_V = 55'(EARTH_RADIUS_M);
	localparam logic [55:0] ROUND_DIST = 56'd536870912;
	localparam logic [25:0] MAX_DIST_V = 26'(MAX_DISTANCE);

	// ------------------------------------------------------------------
	// Pipeline control: one global advance, valid and missing flag travel
	// with the item through every stage.
	// ------------------------------------------------------------------
	logic [DEPTH-1:0] vld_s;
	logic [DEPTH-1:0] miss_s;
	logic adv;
	logic miss_in;

	// Advance whenever the output register is empty or being drained
	assign adv = !vld_s[DEPTH-1] || result.ready;
	assign points.ready = adv;

	// Any coordinate exactly zero marks the item as missing
	assign miss_in = (points.first_latitude == '0) || (points.first_longitude == '0) ||
		(points.second_latitude == '0) || (points.second_longitude == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			miss_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DEPTH-2:0], points.valid};
			miss_s <= {miss_s[DEPTH-2:0], miss_in};
		end
	end

	// ------------------------------------------------------------------
	// Stages 1 to 6: reduce each angle to [-90, 90] degrees and convert
	// to Q30 radians, three lanes side by side.
	// ------------------------------------------------------------------
	logic signed [ANG_IN_W-1:0] lane_in [0:LANES-1];

	assign lane_in[LANE_LAT1] = ANG_IN_W'(points.first_latitude);
	assign lane_in[LANE_LAT2] = ANG_IN_W'(points.second_latitude);
	assign lane_in[LANE_DLON] = ANG_IN_W'(points.first_longitude) -
		ANG_IN_W'(points.second_longitude);

	logic [ANG_IN_W-1:0] abs_c [0:LANES-1];
	logic [2*ANG_IN_W-1:0] quo_prod_c [0:LANES-1];
	logic [RED_W-1:0] rem_raw_c [0:LANES-1];
	logic [RED_W-1:0] rem_c [0:LANES-1];
	logic [RED_W-1:0] wrap_c [0:LANES-1];
	logic signed [RED_W-1:0] turn_c [0:LANES-1];
	logic signed [RED_W-1:0] ang_c [0:LANES-1];
	logic fold_c [0:LANES-1];
	logic [MAG_W-1:0] mag_c [0:LANES-1];
	logic [T_W-1:0] t_c [0:LANES-1];
	logic [U_W-1:0] u_c [0:LANES-1];
	logic [2*U_W-1:0] q45_prod_c [0:LANES-1];
	logic [U_W-1:0] r45_c [0:LANES-1];
	logic [U_W-1:0] uq_c [0:LANES-1];
	logic [T_W:0] dsum_c [0:LANES-1];
	logic signed [CW-1:0] zmag_c [0:LANES-1];

	logic [ANG_IN_W-1:0] abs_s1 [0:LANES-1];
	logic neg_s1 [0:LANES-1];
	logic [ANG_IN_W-1:0] quo_s1 [0:LANES-1];
	logic [RED_W-1:0] rem_s2 [0:LANES-1];
	logic neg_s2 [0:LANES-1];
	logic [MAG_W-1:0] mag_s3 [0:LANES-1];
	logic sgn_s3 [0:LANES-1];
	logic cneg_s3 [0:LANES-1];
	logic [T_W-1:0] t_s4 [0:LANES-1];
	logic [U_W-1:0] u_s4 [0:LANES-1];
	logic sgn_s4 [0:LANES-1];
	logic cneg_s4 [0:LANES-1];
	logic [T_W-1:0] t_s5 [0:LANES-1];
	logic [U_W-1:0] u_s5 [0:LANES-1];
	logic [U_W-1:0] q45_s5 [0:LANES-1];
	logic sgn_s5 [0:LANES-1];
	logic cneg_s5 [0:LANES-1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			// Stage 1: magnitude and estimated turn count
			abs_c[l] = lane_in[l][ANG_IN_W-1] ? ANG_IN_W'(-lane_in[l]) : ANG_IN_W'(lane_in[l]);
			quo_prod_c[l] = {{ANG_IN_W{1'b0}}, abs_c[l]} * {{ANG_IN_W{1'b0}}, FULL_RECIP_V};

			// Stage 2: remainder, the estimate is at most one turn short
			rem_raw_c[l] = RED_W'(abs_s1[l]) - RED_W'(quo_s1[l]) * FULL_V;
			rem_c[l] = (rem_raw_c[l] >= FULL_V) ? rem_raw_c[l] - FULL_V : rem_raw_c[l];

			// Stage 3: wrap into [-180, 180) then fold into the right half-plane
			wrap_c[l] = (neg_s2[l] && rem_s2[l] != '0) ? FULL_V - rem_s2[l] : rem_s2[l];
			turn_c[l] = (wrap_c[l] >= HALF_V) ? wrap_c[l] - FULL_V : wrap_c[l];
			ang_c[l] = turn_c[l];
			fold_c[l] = 1'b0;
			if (turn_c[l] > QUARTER_S) begin
				ang_c[l] = HALF_S - turn_c[l];
				fold_c[l] = 1'b1;
			end else if (turn_c[l] < NEG_QUARTER_S) begin
				ang_c[l] = NEG_HALF_S - turn_c[l];
				fold_c[l] = 1'b1;
			end
			mag_c[l] = ang_c[l][RED_W-1] ? MAG_W'(-ang_c[l]) : MAG_W'(ang_c[l]);

			// Stage 4: split the scaling by pi/180 into an exact part and a small rest
			t_c[l] = T_W'(mag_s3[l]) * PI_HI_V;
			u_c[l] = U_W'(mag_s3[l]) * PI_LO_V + U_OFFSET;

			// Stage 5: estimate the rest divided by 45
			q45_prod_c[l] = {{U_W{1'b0}}, u_s4[l]} * {{U_W{1'b0}}, RECIP45_V};

			// Stage 6: correct the estimate and drop the fraction bits
			r45_c[l] = u_s5[l] - q45_s5[l] * DIV45_V;
			uq_c[l] = (r45_c[l] >= DIV45_V) ? q45_s5[l] + U_W'(1) : q45_s5[l];
			dsum_c[l] = (T_W+1)'(t_s5[l]) + (T_W+1)'(uq_c[l]);
			zmag_c[l] = CW'(dsum_c[l] >> (ANGLE_FRAC_BITS + 2));
		end
	end

	// ------------------------------------------------------------------
	// Rotation CORDIC: index 0 is stage 6, each index one stage on.
	// ------------------------------------------------------------------
	logic signed [CW-1:0] rot_x_s [0:CORDIC_STEPS][0:LANES-1];
	logic signed [CW-1:0] rot_y_s [0:CORDIC_STEPS][0:LANES-1];
	logic signed [CW-1:0] rot_z_s [0:CORDIC_STEPS][0:LANES-1];
	logic rot_cneg_s [0:CORDIC_STEPS][0:LANES-1];

	// ------------------------------------------------------------------
	// Stages 37 to 40: combine the sines and cosines into v, clamp, square.
	// ------------------------------------------------------------------
	logic signed [31:0] sin_c [0:LANES-1];
	logic signed [31:0] cos_c [0:LANES-1];
	logic signed [63:0] ccp_c;
	logic signed [63:0] ss_c;
	logic signed [63:0] sum_c;
	logic signed [63:0] vr_c;
	logic signed [31:0] vcl_c;

	logic signed [31:0] cc_s37;
	logic signed [63:0] ss_s37;
	logic signed [31:0] cd_s37;
	logic signed [63:0] pc_s38;
	logic signed [63:0] ss_s38;
	logic signed [31:0] v_s39;
	logic signed [63:0] vsq_s40;
	logic signed [31:0] v_s40;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sin_c[l] = 32'(rot_y_s[CORDIC_STEPS][l]);
			cos_c[l] = rot_cneg_s[CORDIC_STEPS][l] ? 32'(-rot_x_s[CORDIC_STEPS][l]) :
				32'(rot_x_s[CORDIC_STEPS][l]);
		end
		ccp_c = cos_c[LANE_LAT1] * cos_c[LANE_LAT2];
		ss_c = sin_c[LANE_LAT1] * sin_c[LANE_LAT2];
		sum_c = ss_s38 + pc_s38;
		vr_c = (sum_c + ROUND_Q30) >>> 30;
		if (vr_c > V_MAX) begin
			vcl_c = 32'(V_MAX);
		end else if (vr_c < V_MIN) begin
			vcl_c = 32'(V_MIN);
		end else begin
			vcl_c = 32'(vr_c);
		end
	end

	// ------------------------------------------------------------------
	// Square root of 1 - v^2, one result bit per stage. Index 0 is stage 41.
	// ------------------------------------------------------------------
	logic [60:0] sq_n_s [0:SQRT_STEPS];
	logic [61:0] sq_r_s [0:SQRT_STEPS];
	logic signed [31:0] sq_v_s [0:SQRT_STEPS];

	// ------------------------------------------------------------------
	// Vectoring CORDIC for arccos. Index 0 is the quadrant swap, stage 73.
	// ------------------------------------------------------------------
	logic signed [CW-1:0] vec_x_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] vec_y_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] vec_z_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] root_c;
	logic signed [CW-1:0] vext_c;

	assign root_c = CW'(sq_r_s[SQRT_STEPS][30:0]);
	assign vext_c = CW'(sq_v_s[SQRT_STEPS]);

	// ------------------------------------------------------------------
	// Stages 104 and 105: scale the angle by the Earth radius, round, clamp.
	// ------------------------------------------------------------------
	logic [31:0] zpos_c;
	logic [55:0] dq_c;
	logic [54:0] dp_s104;
	logic [DIST_W-1:0] dist_s105;

	assign zpos_c = vec_z_s[CORDIC_STEPS][CW-1] ? 32'd0 : vec_z_s[CORDIC_STEPS][31:0];
	assign dq_c = ({1'b0, dp_s104} + ROUND_DIST) >> 30;

	// ------------------------------------------------------------------
	// Datapath registers: hold on stall, advance together.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				abs_s1[l] <= abs_c[l];
				neg_s1[l] <= lane_in[l][ANG_IN_W-1];
				quo_s1[l] <= quo_prod_c[l][2*ANG_IN_W-1:ANG_IN_W];

				rem_s2[l] <= rem_c[l];
				neg_s2[l] <= neg_s1[l];

				mag_s3[l] <= mag_c[l];
				sgn_s3[l] <= ang_c[l][RED_W-1];
				cneg_s3[l] <= fold_c[l];

				t_s4[l] <= t_c[l];
				u_s4[l] <= u_c[l];
				sgn_s4[l] <= sgn_s3[l];
				cneg_s4[l] <= cneg_s3[l];

				t_s5[l] <= t_s4[l];
				u_s5[l] <= u_s4[l];
				q45_s5[l] <= q45_prod_c[l][2*U_W-1:U_W];
				sgn_s5[l] <= sgn_s4[l];
				cneg_s5[l] <= cneg_s4[l];

				rot_x_s[0][l] <= GAIN_INV_V;
				rot_y_s[0][l] <= '0;
				rot_z_s[0][l] <= sgn_s5[l] ? -zmag_c[l] : zmag_c[l];
				rot_cneg_s[0][l] <= cneg_s5[l];

				// Rotate towards zero residual angle
				for (int k = 0; k < CORDIC_STEPS; k++) begin
					if (rot_z_s[k][l] >= 0) begin
						rot_x_s[k+1][l] <= rot_x_s[k][l] - (rot_y_s[k][l] >>> k);
						rot_y_s[k+1][l] <= rot_y_s[k][l] + (rot_x_s[k][l] >>> k);
						rot_z_s[k+1][l] <= rot_z_s[k][l] - signed'(CW'(ATAN_Q30[k]));
					end else begin
						rot_x_s[k+1][l] <= rot_x_s[k][l] + (rot_y_s[k][l] >>> k);
						rot_y_s[k+1][l] <= rot_y_s[k][l] - (rot_x_s[k][l] >>> k);
						rot_z_s[k+1][l] <= rot_z_s[k][l] + signed'(CW'(ATAN_Q30[k]));
					end
					rot_cneg_s[k+1][l] <= rot_cneg_s[k][l];
				end
			end

			cc_s37 <= 32'((ccp_c + ROUND_Q30) >>> 30);
			ss_s37 <= ss_c;
			cd_s37 <= cos_c[LANE_DLON];

			pc_s38 <= cc_s37 * cd_s37;
			ss_s38 <= ss_s37;

			v_s39 <= vcl_c;

			vsq_s40 <= v_s39 * v_s39;
			v_s40 <= v_s39;

			sq_n_s[0] <= 61'(ONE_Q60 - vsq_s40);
			sq_r_s[0] <= '0;
			sq_v_s[0] <= v_s40;

			// Accept the trial bit where the remainder allows it
			for (int k = 0; k < SQRT_STEPS; k++) begin
				if ({2'b00, sq_n_s[k]} >= ({1'b0, sq_r_s[k]} +
					{1'b0, 62'(62'd1 << (60 - 2*k))})) begin
					sq_n_s[k+1] <= 61'({2'b00, sq_n_s[k]} - ({1'b0, sq_r_s[k]} +
						{1'b0, 62'(62'd1 << (60 - 2*k))}));
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + 62'(62'd1 << (60 - 2*k));
				end else begin
					sq_n_s[k+1] <= sq_n_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
				sq_v_s[k+1] <= sq_v_s[k];
			end

			// Negative v: start a quarter turn on so x stays positive
			if (vext_c < 0) begin
				vec_x_s[0] <= root_c;
				vec_y_s[0] <= -vext_c;
				vec_z_s[0] <= HALF_PI_V;
			end else begin
				vec_x_s[0] <= vext_c;
				vec_y_s[0] <= root_c;
				vec_z_s[0] <= '0;
			end

			// Drive y to zero, accumulating the angle
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				if (vec_y_s[k] > 0) begin
					vec_x_s[k+1] <= vec_x_s[k] + (vec_y_s[k] >>> k);
					vec_y_s[k+1] <= vec_y_s[k] - (vec_x_s[k] >>> k);
					vec_z_s[k+1] <= vec_z_s[k] + signed'(CW'(ATAN_Q30[k]));
				end else begin
					vec_x_s[k+1] <= vec_x_s[k] - (vec_y_s[k] >>> k);
					vec_y_s[k+1] <= vec_y_s[k] + (vec_x_s[k] >>> k);
					vec_z_s[k+1] <= vec_z_s[k] - signed'(CW'(ATAN_Q30[k]));
				end
			end

			dp_s104 <= 55'(zpos_c) * RADIUS_V;

			// Drop the distance for a missing coordinate
			if (miss_s[DEPTH-2]) begin
				dist_s105 <= '0;
			end else if (dq_c[25:0] > MAX_DIST_V) begin
				dist_s105 <= DIST_W'(MAX_DIST_V);
			end else begin
				dist_s105 <= dq_c[DIST_W-1:0];
			end
		end
	end

	assign result.valid = vld_s[DEPTH-1];
	assign result.distance_m = dist_s105;
	assign result.missing_coordinate = miss_s[DEPTH-1];

endmodule

// ===== bench/tb_great_circle_distance.sv =====
`timescale 1ns / 1ps

module tb_great_circle_distance import gcdist_pkg::*; ();

	localparam int IDLE_PCT = 26;
	localparam int RANDOM_ITEMS = 1750;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint MAX_DIST = 20015087;

	typedef struct packed {
		logic signed [LAT_W-1:0] lat1;
		logic signed [LON_W-1:0] lon1;
		logic signed [LAT_W-1:0] lat2;
		logic signed [LON_W-1:0] lon2;
	} point_pair_t;

	typedef struct packed {
		logic [DIST_W-1:0] metres;
		logic missing;
	} distance_t;

	// Arctangent table, Q30 radians
	localparam longint ARCTAN [0:29] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048576, 524288, 262144, 131072, 65536,
		32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64,
		32, 16, 8, 4, 2
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gcdist_in_if points();
	gcdist_out_if result();

	great_circle_distance uut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	point_pair_t pending_pairs[$];
	distance_t expected_distances[$];
	int mismatches = 0;
	bit stimulus_done = 1'b0;
	bit calm_stretch = 1'b0;
	bit hold_sender = 1'b0;
	longint cycle_count = 0;

	// Degrees (fixed point) to Q30 radians, rounded to nearest on the magnitude
	function automatic longint degrees_to_q30(input longint d);
		longint m;
		longint divisor;
		longint r;
		m = (d < 0) ? -d : d;
		divisor = longint'(180) << ANGLE_FRAC_BITS;
		r = (m * longint'(64'd3373259426) + (divisor >>> 1)) / divisor;
		return (d < 0) ? -r : r;
	endfunction

	// Rotation CORDIC after folding the angle into +-90 degrees
	function automatic void sine_cosine(input longint d, output longint s, output longint c);
		longint full;
		longint half;
		longint quarter;
		longint r;
		longint x;
		longint y;
		longint z;
		longint nx;
		bit flip;
		full = longint'(360) << ANGLE_FRAC_BITS;
		half = longint'(180) << ANGLE_FRAC_BITS;
		quarter = longint'(90) << ANGLE_FRAC_BITS;
		r = ((d % full) + full) % full;
		flip = 1'b0;
		if (r >= half) r -= full;
		if (r > quarter) begin
			r = half - r;
			flip = 1'b1;
		end else if (r < -quarter) begin
			r = -half - r;
			flip = 1'b1;
		end
		z = degrees_to_q30(r);
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint int_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// Vectoring CORDIC arccos, Q30 in and out
	function automatic longint arccos_q30(input longint v);
		longint x;
		longint y;
		longint z;
		longint nx;
		longint t;
		x = v;
		z = 0;
		y = int_sqrt((64'd1 << 60) - longint'(v * v));
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = 1686629713;
		end
		for (int i = 0; i < 30; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN[i];
			end
			x = nx;
		end
		return (z < 0) ? 0 : z;
	endfunction

	function automatic distance_t predict_distance(input point_pair_t p);
		distance_t e;
		longint s1, c1, s2, c2, sd, cd, cc, v;
		longint unsigned dm;
		if (p.lat1 == 0 || p.lon1 == 0 || p.lat2 == 0 || p.lon2 == 0) begin
			e.metres = '0;
			e.missing = 1'b1;
			return e;
		end
		sine_cosine(longint'(p.lat1), s1, c1);
		sine_cosine(longint'(p.lat2), s2, c2);
		sine_cosine(longint'(p.lon1) - longint'(p.lon2), sd, cd);
		cc = (c1 * c2 + (longint'(1) << 29)) >>> 30;
		v = (s1 * s2 + cc * cd + (longint'(1) << 29)) >>> 30;
		if (v > (longint'(1) << 30)) v = longint'(1) << 30;
		if (v < -(longint'(1) << 30)) v = -(longint'(1) << 30);
		dm = (longint'(arccos_q30(v)) * 64'd6371000 + (64'd1 << 29)) >> 30;
		if (dm > MAX_DIST) dm = MAX_DIST;
		e.metres = dm[DIST_W-1:0];
		e.missing = 1'b0;
		return e;
	endfunction

	// Random coordinate; a zero now and then marks a missing one
	function automatic longint random_coord(input longint span, input int w);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3) return 0;
		if (pick < 8) return $urandom_range(0, 1) ? span : -span;
		if (pick < 12) begin
			// Out of range: any bit pattern of the field width
			return (longint'($urandom) << (64 - w)) >>> (64 - w);
		end
		if (pick < 16) return longint'($urandom_range(0, 200)) - 100;
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic point_pair_t make_pair(input longint a, input longint b,
			input longint c, input longint d);
		point_pair_t p;
		p.lat1 = a[LAT_W-1:0];
		p.lon1 = b[LON_W-1:0];
		p.lat2 = c[LAT_W-1:0];
		p.lon2 = d[LON_W-1:0];
		return p;
	endfunction

	// Fill the pending queue: directed corners first, then random pairs
	initial begin
		longint deg;
		longint lat_max;
		longint lon_max;
		deg = longint'(1) << ANGLE_FRAC_BITS;
		lat_max = 90 * deg;
		lon_max = 180 * deg;
		// Missing coordinate in each position, and all four
		pending_pairs.push_back(make_pair(0, deg, deg, deg));
		pending_pairs.push_back(make_pair(deg, 0, deg, deg));
		pending_pairs.push_back(make_pair(deg, deg, 0, deg));
		pending_pairs.push_back(make_pair(deg, deg, deg, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 0));
		// Same point: clamps at v = 1
		pending_pairs.push_back(make_pair(45 * deg, 30 * deg, 45 * deg, 30 * deg));
		pending_pairs.push_back(make_pair(1, 1, 1, 1));
		// Pole to pole (the distance ceiling), points across the date line, one pole twice
		pending_pairs.push_back(make_pair(lat_max, deg, -lat_max, deg));
		pending_pairs.push_back(make_pair(deg, lon_max, -deg, -lon_max + 1));
		pending_pairs.push_back(make_pair(-lat_max, -lon_max, lat_max, lon_max));
		pending_pairs.push_back(make_pair(lat_max, lon_max, lat_max, -lon_max));
		// Field extremes out of the nominal range, then assorted edge cases
		pending_pairs.push_back(make_pair(-(longint'(1) << 23), -(longint'(1) << 24),
			(longint'(1) << 23) - 1, (longint'(1) << 24) - 1));
		pending_pairs.push_back(make_pair(-1, -1, -1, 1));
		pending_pairs.push_back(make_pair(100 * deg, 270 * deg, -100 * deg, -270 * deg));
		pending_pairs.push_back(make_pair(lat_max - 1, 1, -lat_max + 1, -1));
		pending_pairs.push_back(make_pair(12 * deg + 7, 77 * deg, -12 * deg, 103 * deg));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pending_pairs.push_back(make_pair(random_coord(lat_max, LAT_W),
				random_coord(lon_max, LON_W), random_coord(lat_max, LAT_W),
				random_coord(lon_max, LON_W)));
		end
	end

	// Reset once, then let the bench run
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: present the head of the queue; idle at random outside the calm stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points.valid <= 1'b0;
			points.first_latitude <= '0;
			points.first_longitude <= '0;
			points.second_latitude <= '0;
			points.second_longitude <= '0;
		end else begin
			point_pair_t next_pair;
			bit accepted;
			accepted = points.valid && points.ready;
			if (accepted) begin
				expected_distances.push_back(predict_distance(pending_pairs.pop_front()));
				// Hold back once mid-run until the pipe drains
				if (pending_pairs.size() == RANDOM_ITEMS / 2) hold_sender = 1'b1;
			end
			if (hold_sender && expected_distances.size() == 0) hold_sender = 1'b0;
			if (!points.valid || accepted) begin
				if (pending_pairs.size() != 0 && !hold_sender &&
						(calm_stretch || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_pair = pending_pairs[0];
					points.valid <= 1'b1;
					points.first_latitude <= next_pair.lat1;
					points.first_longitude <= next_pair.lon1;
					points.second_latitude <= next_pair.lat2;
					points.second_longitude <= next_pair.lon2;
				end else begin
					points.valid <= 1'b0;
				end
			end
			if (pending_pairs.size() == 0 && !points.valid) stimulus_done = 1'b1;
		end
	end

	// Monitor: check each accepted result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			distance_t want;
			if (result.valid && result.ready) begin
				if (expected_distances.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: dist=%0d missing=%0b",
							result.distance_m, result.missing_coordinate);
				end else begin
					want = expected_distances.pop_front();
					if (result.distance_m !== want.metres ||
							result.missing_coordinate !== want.missing) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result wrong: want dist=%0d missing=%0b, got dist=%0d missing=%0b",
								want.metres, want.missing, result.distance_m,
								result.missing_coordinate);
					end
				end
			end
			result.ready <= calm_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Calm stretch: no idling on either side for a while in the middle of the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		calm_stretch <= (cycle_count >= 800 && cycle_count < 1400);
	end

	initial begin
		wait (arst_n);
		while (!(stimulus_done && expected_distances.size() == 0)
				&& cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("great_circle_distance: mismatch");
			$finish;
		end else begin
			// Allow stray late results to show up
			repeat (DEPTH + 20) @(posedge clk);
			if (mismatches == 0 && expected_distances.size() == 0)
				$display("great_circle_distance: match");
			else
				$display("great_circle_distance: mismatch");
			$finish;
		end
	end

endmodule
